// ===== src/lrrb_pkg.sv =====
// Shared types, constants and the pointer helper function of the line receive ring buffer.
package lrrb_pkg;

   localparam int BUF_DEPTH = 32;
   localparam int PTR_W     = $clog2(BUF_DEPTH);

   localparam logic [7:0] TERM_RESET = 8'h0A;
   localparam logic [7:0] CLOSE_BYTE = 8'h00;

   localparam logic REPLY_LINE  = 1'b0;
   localparam logic REPLY_QUERY = 1'b1;

   typedef enum logic [1:0] {
      CMD_PUSH     = 2'd0,
      CMD_GET_LINE = 2'd1,
      CMD_QUERY    = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GET_ISSUE,
      ST_GET_DATA,
      ST_QRY_ISSUE,
      ST_QRY_DATA
   } state_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       reply_kind;
      logic [7:0] data_byte;
      logic       line_present;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic             wr_en;
      logic [PTR_W-1:0] wr_addr;
      logic [7:0]       wr_data;
      logic             rd_en;
      logic [PTR_W-1:0] rd_addr;
   } mem_req_type;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(BUF_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

endpackage

// ===== src/lrrb_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module lrrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/lrrb_seq.sv =====
// Command sequencer: pointers, store accesses and the registered result word.
module lrrb_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  lrrb_pkg::req_type   req_data,
   input  logic [7:0]          term_char,
   input  logic [7:0]          mem_rd_data,
   output lrrb_pkg::mem_req_type mem_req,
   output logic                busy,
   output logic                rsp_valid,
   output lrrb_pkg::rsp_type   rsp_data
);
   import lrrb_pkg::*;

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] scan_ff, scan_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      scan_in      = scan_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_req      = '{wr_en: 1'b0, wr_addr: wr_ptr_ff, wr_data: req_data.rx_byte,
                       rd_en: 1'b0, rd_addr: rd_ptr_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_data.cmd)
                  CMD_PUSH: begin
                     // No overflow guard: an overrun silently overwrites old bytes.
                     mem_req.wr_en = 1'b1;
                     wr_ptr_in     = ptr_next(wr_ptr_ff);
                  end
                  CMD_GET_LINE: state_in = ST_GET_ISSUE;
                  CMD_QUERY: begin
                     scan_in  = rd_ptr_ff;
                     state_in = ST_QRY_ISSUE;
                  end
                  default: ;
               endcase
            end
         end
         ST_GET_ISSUE: begin
            if (rd_ptr_ff == wr_ptr_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{REPLY_LINE, CLOSE_BYTE, 1'b0, 1'b1};
               state_in     = ST_IDLE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = rd_ptr_ff;
               state_in        = ST_GET_DATA;
            end
         end
         ST_GET_DATA: begin
            // The byte is consumed whether it is the terminator or not.
            rd_ptr_in    = ptr_next(rd_ptr_ff);
            rsp_valid_in = 1'b1;
            if (mem_rd_data == term_char) begin
               rsp_in   = '{REPLY_LINE, CLOSE_BYTE, 1'b0, 1'b1};
               state_in = ST_IDLE;
            end else begin
               rsp_in   = '{REPLY_LINE, mem_rd_data, 1'b0, 1'b0};
               state_in = ST_GET_ISSUE;
            end
         end
         ST_QRY_ISSUE: begin
            if (scan_ff == wr_ptr_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{REPLY_QUERY, CLOSE_BYTE, 1'b0, 1'b1};
               state_in     = ST_IDLE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = scan_ff;
               state_in        = ST_QRY_DATA;
            end
         end
         ST_QRY_DATA: begin
            if (mem_rd_data == term_char) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{REPLY_QUERY, CLOSE_BYTE, 1'b1, 1'b1};
               state_in     = ST_IDLE;
            end else begin
               scan_in  = ptr_next(scan_ff);
               state_in = ST_QRY_ISSUE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/line_receive_ring_buffer.sv =====
// Top level of the line receive ring buffer: terminator register, byte store, sequencer.
//
// Serial bytes are pushed into a 32-entry circular byte store and read back as lines.
// Command channel: a word on req_data (cmd, rx_byte) is taken at a rising edge where
// start is high and busy is low.
//   Push stores rx_byte at the write pointer and gives no result;
//   busy stays low, so pushes can follow back to back. There is no overflow guard.
//   Get line emits the pending bytes up to the terminator, consumes the terminator
//   and closes with a zero byte marked last. Each stored byte is read from the RAM
//   and then compared with the terminator.
//   Query scans the pending bytes without consuming them and answers with one word,
//   line_present set if the terminator was found, with a read and a compare per byte.
// The pace is set by the single read port of the byte store and its registered read.
// Results appear on rsp_data for exactly one cycle, marked by rsp_valid; the receiver
// cannot hold them off. The last word of a command coincides with busy falling, so
// the next command may be given in that very cycle. csr_we/csr_wdata write the
// terminator (reset value line feed); the user must do so only while idle, as the block
// does not enforce it. Reset clears the pointers and the sequencer, not the store.
module line_receive_ring_buffer (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  lrrb_pkg::req_type req_data,
   output logic              busy,
   output logic              rsp_valid,
   output lrrb_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [7:0]        csr_wdata
);
   import lrrb_pkg::*;

   logic [7:0]  term_ff, term_in;
   mem_req_type mem_req;
   logic [7:0]  mem_rd_data;

   always_comb begin
      term_in = csr_we ? csr_wdata : term_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_ff <= TERM_RESET;
      end else begin
         term_ff <= term_in;
      end
   end

   lrrb_ram #(
      .WIDTH (8),
      .DEPTH (BUF_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data)
   );

   lrrb_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_data    (req_data),
      .term_char   (term_ff),
      .mem_rd_data (mem_rd_data),
      .mem_req     (mem_req),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   // The final word of a command is shown exactly when the sequencer is free again.
   a_last_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == !busy))
      else $error("last flag disagrees with sequencer state");

   a_read_cmd_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.cmd == CMD_GET_LINE || req_data.cmd == CMD_QUERY))
      |=> busy)
      else $error("get line or query did not occupy the sequencer");

   a_query_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.reply_kind == REPLY_QUERY) |-> rsp_data.last)
      else $error("query answer not marked last");

   a_line_no_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.reply_kind == REPLY_LINE) |-> !rsp_data.line_present)
      else $error("line word carries a query flag");

   a_no_store_write_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !mem_req.wr_en)
      else $error("store written during a read sequence");

endmodule

// ===== tb/sv/lrrb_line_checker.sv =====
// Checker that predicts every reply word of the line receive ring buffer and compares it.
module lrrb_line_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  lrrb_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  lrrb_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [7:0]        csr_wdata,
   output int                mismatch_count,
   output int                words_outstanding
);
   import lrrb_pkg::*;

   logic [7:0]       line_store [BUF_DEPTH];
   logic [PTR_W-1:0] fill_ptr;
   logic [PTR_W-1:0] drain_ptr;
   logic [7:0]       line_end;
   rsp_type          reply_words [$];

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      return PTR_W'((int'(p) + 1) % BUF_DEPTH);
   endfunction

   function automatic rsp_type make_word(input logic kind, input logic [7:0] data,
                                         input logic present, input logic fin);
      rsp_type w;
      w.reply_kind   = kind;
      w.data_byte    = data;
      w.line_present = present;
      w.last         = fin;
      return w;
   endfunction

   task automatic predict_replies(input req_type r);
      logic [PTR_W-1:0] scan;
      logic [7:0]       b;
      logic             hit;
      int               n;
      n   = 0;
      hit = 1'b0;
      case (r.cmd)
         CMD_PUSH: begin
            line_store[fill_ptr] = r.rx_byte;
            fill_ptr = wrap_inc(fill_ptr);
         end
         CMD_GET_LINE: begin
            // At most one word short of the store depth is emitted before the closing zero.
            while (drain_ptr != fill_ptr && n < BUF_DEPTH - 1 && !hit) begin
               b = line_store[drain_ptr];
               drain_ptr = wrap_inc(drain_ptr);
               if (b == line_end) begin
                  hit = 1'b1;
               end else begin
                  reply_words.push_back(make_word(REPLY_LINE, b, 1'b0, 1'b0));
                  n++;
               end
            end
            reply_words.push_back(make_word(REPLY_LINE, CLOSE_BYTE, 1'b0, 1'b1));
         end
         CMD_QUERY: begin
            scan = drain_ptr;
            while (scan != fill_ptr && !hit) begin
               hit  = (line_store[scan] == line_end);
               scan = wrap_inc(scan);
            end
            reply_words.push_back(make_word(REPLY_QUERY, 8'h00, hit, 1'b1));
         end
         default: begin
         end
      endcase
   endtask

   task automatic check_word(input rsp_type got);
      rsp_type want;
      if (reply_words.size() == 0) begin
         if (mismatch_count < 10) begin
            $display("unexpected reply word: kind %0d data %02h present %0d last %0d",
                     got.reply_kind, got.data_byte, got.line_present, got.last);
         end
         mismatch_count++;
      end else begin
         want = reply_words.pop_front();
         if (got.reply_kind !== want.reply_kind || got.data_byte !== want.data_byte ||
             got.line_present !== want.line_present || got.last !== want.last) begin
            if (mismatch_count < 10) begin
               $display({"reply mismatch: expected kind %0d data %02h present %0d last %0d,",
                         " got kind %0d data %02h present %0d last %0d"},
                        want.reply_kind, want.data_byte, want.line_present, want.last,
                        got.reply_kind, got.data_byte, got.line_present, got.last);
            end
            mismatch_count++;
         end
      end
   endtask

   // Replies are checked before the command taken at the same edge is predicted;
   // a command's first reply never comes at the edge that takes it.
   always @(posedge clock) begin
      if (reset) begin
         fill_ptr  = '0;
         drain_ptr = '0;
         line_end  = TERM_RESET;
         reply_words.delete();
      end else begin
         if (rsp_valid) begin
            check_word(rsp_data);
         end
         if (csr_we) begin
            line_end = csr_wdata;
         end
         if (start && !busy) begin
            predict_replies(req_data);
         end
      end
      words_outstanding = reply_words.size();
   end

endmodule

// ===== tb/sv/tb_line_receive_ring_buffer.sv =====
// Testbench top of the line receive ring buffer: clock, reset, command stimulus and verdict.
module tb_line_receive_ring_buffer;
   import lrrb_pkg::*;

   localparam logic [1:0] CMD_UNUSED      = 2'd3;
   localparam int         SETTLE_CYCLES   = 80;
   localparam int         CYCLE_LIMIT     = 400000;
   localparam int         WORDS_PER_PHASE = 67;

   logic       clock = 1'b0;
   logic       reset;
   logic       start;
   req_type    req_data;
   logic       busy;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_we;
   logic [7:0] csr_wdata;

   int         mismatch_count;
   int         words_outstanding;
   int         cycle_count = 0;
   int         sent;
   bit         calm;
   logic [7:0] line_end;

   line_receive_ring_buffer uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   lrrb_line_checker line_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_data          (rsp_data),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatch_count),
      .words_outstanding (words_outstanding)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** line_receive_ring_buffer: FAILED **");
         $finish;
      end
   end

   // A data byte that differs from the current terminator.
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == line_end) begin
         b = ~b;
      end
      return b;
   endfunction

   // Start stays high from one word to the next unless an idle burst is inserted.
   task automatic issue(input logic [1:0] cmd, input logic [7:0] data);
      if (!calm && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start            <= 1'b1;
      req_data.cmd     <= cmd;
      req_data.rx_byte <= data;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (cmd != CMD_UNUSED) begin
         sent++;
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (words_outstanding != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [7:0] term, input bit quiet);
      int goal;
      int kind;
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= term;
      line_end   = term;
      @(posedge clock);
      csr_we <= 1'b0;
      goal = sent + WORDS_PER_PHASE;
      while (sent < goal) begin
         calm = quiet || ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            // A line of random content, mostly closed by the terminator.
            repeat ($urandom_range(0, 12)) begin
               if ($urandom_range(0, 5) == 0) begin
                  issue(CMD_PUSH, 8'($urandom_range(0, 255)));
               end else begin
                  issue(CMD_PUSH, plain_byte());
               end
            end
            if ($urandom_range(0, 3) != 0) begin
               issue(CMD_PUSH, line_end);
            end
            if ($urandom_range(0, 2) == 0) begin
               issue(CMD_QUERY, 8'($urandom_range(0, 255)));
            end
            issue(CMD_GET_LINE, 8'($urandom_range(0, 255)));
         end else if (kind == 6) begin
            // Fill the store close to or past its depth, so the write pointer may wrap past the read pointer.
            repeat ($urandom_range(28, 40)) issue(CMD_PUSH, plain_byte());
            issue(CMD_QUERY, 8'($urandom_range(0, 255)));
            issue(CMD_GET_LINE, 8'($urandom_range(0, 255)));
            issue(CMD_GET_LINE, 8'($urandom_range(0, 255)));
         end else if (kind <= 8) begin
            repeat ($urandom_range(1, 6)) begin
               issue(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
         end else begin
            issue(CMD_QUERY, 8'($urandom_range(0, 255)));
            issue(CMD_GET_LINE, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_wdata = 8'h00;
      calm      = 1'b0;
      sent      = 0;
      line_end  = TERM_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Empty store, a stored zero byte, extreme bytes, a line without terminator
      // and the unused command, all with the line feed terminator.
      issue(CMD_GET_LINE, 8'h00);
      issue(CMD_QUERY, 8'hFF);
      issue(CMD_PUSH, 8'h00);
      issue(CMD_PUSH, 8'hFF);
      issue(CMD_PUSH, TERM_RESET);
      issue(CMD_QUERY, 8'h00);
      issue(CMD_GET_LINE, 8'hFF);
      issue(CMD_PUSH, 8'h41);
      issue(CMD_QUERY, 8'h00);
      issue(CMD_GET_LINE, 8'h00);
      issue(CMD_UNUSED, 8'hFF);
      issue(CMD_GET_LINE, 8'h00);

      run_phase(8'h00, 1'b0);
      run_phase(8'hFF, 1'b0);
      run_phase(8'($urandom_range(0, 255)), 1'b0);
      run_phase(TERM_RESET, 1'b0);
      run_phase(8'($urandom_range(0, 255)), 1'b0);
      run_phase(8'($urandom_range(0, 255)), 1'b1);
      settle();

      if (mismatch_count == 0 && words_outstanding == 0) begin
         $display("** line_receive_ring_buffer: PASSED **");
      end else begin
         $display("** line_receive_ring_buffer: FAILED **");
      end
      $finish;
   end

endmodule
